// ===== rtl/tbb_pkg.sv =====
`default_nettype none

package tbb_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RegW     = 64;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_XROW_XY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_XROW_ZT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_YROW_XY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_YROW_ZT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ZROW_XY = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ZROW_ZT = 3'd5;

  localparam logic [RegW-1:0] XROW_XY_RST = 64'h0001_0000_0000_0000;
  localparam logic [RegW-1:0] XROW_ZT_RST = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] YROW_XY_RST = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] YROW_ZT_RST = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] ZROW_XY_RST = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] ZROW_ZT_RST = 64'h0001_0000_0000_0000;

  localparam logic signed [CoordW-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] POS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vec_t;

  function automatic logic signed [CoordW-1:0] smin(input logic signed [CoordW-1:0] a,
                                                    input logic signed [CoordW-1:0] b);
    smin = (b < a) ? b : a;
  endfunction

  function automatic logic signed [CoordW-1:0] smax(input logic signed [CoordW-1:0] a,
                                                    input logic signed [CoordW-1:0] b);
    smax = (b > a) ? b : a;
  endfunction

  function automatic vec_t vmin(input vec_t a, input vec_t b);
    vec_t r;
    r.x = smin(a.x, b.x);
    r.y = smin(a.y, b.y);
    r.z = smin(a.z, b.z);
    vmin = r;
  endfunction

  function automatic vec_t vmax(input vec_t a, input vec_t b);
    vec_t r;
    r.x = smax(a.x, b.x);
    r.y = smax(a.y, b.y);
    r.z = smax(a.z, b.z);
    vmax = r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/transformed_bounding_box_top.sv =====
`default_nettype none

// Channel  Direction  Word                                        Marker
// in_      slave      tdata[95:0] = pos_x, pos_y, pos_z            tlast = last_vertex
// out_     master     tdata[191:0] = world min x,y,z, max x,y,z    none
// cfg_     write      index 0..5 selects a 64-bit matrix register  none
//
// One vertex is taken per cycle. A last vertex passes the input, box, row product,
// select and sum registers; the output word is then loaded with the updated world
// box. The transform pipeline holds while the output word waits, and only a last
// vertex arriving behind a full pipeline stalls the input. Reset (synchronous,
// active low) empties the local and world boxes and loads the identity matrix.
module transformed_bounding_box_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [95:0]                      in_tdata,   // pos_x, pos_y, pos_z
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [191:0]                          out_tdata,  // min x, y, z, max x, y, z
  input  wire logic                             cfg_we,
  input  wire logic [tbb_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [tbb_pkg::RegW-1:0]         cfg_data
);
  import tbb_pkg::*;

  logic [RegW-1:0] xrow_xy_r, xrow_zt_r, yrow_xy_r, yrow_zt_r, zrow_xy_r, zrow_zt_r;

  logic a_valid_r, a_last_r;
  vec_t a_pos_r;
  vec_t loc_lo_r, loc_hi_r, loc_lo_nxt, loc_hi_nxt;
  vec_t box_lo_r, box_hi_r;
  logic b_valid_r, c_valid_r, d_valid_r, e_valid_r, out_valid_r;
  logic pipe_en, b_free, a_adv, b_load;
  vec_t world_lo_r, world_hi_r, world_lo_nxt, world_hi_nxt;
  wire vec_t row_lo, row_hi;
  logic [191:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xrow_xy_r <= XROW_XY_RST;
      xrow_zt_r <= XROW_ZT_RST;
      yrow_xy_r <= YROW_XY_RST;
      yrow_zt_r <= YROW_ZT_RST;
      zrow_xy_r <= ZROW_XY_RST;
      zrow_zt_r <= ZROW_ZT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XROW_XY: xrow_xy_r <= cfg_data;
        REG_XROW_ZT: xrow_zt_r <= cfg_data;
        REG_YROW_XY: yrow_xy_r <= cfg_data;
        REG_YROW_ZT: yrow_zt_r <= cfg_data;
        REG_ZROW_XY: zrow_xy_r <= cfg_data;
        REG_ZROW_ZT: zrow_zt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pipe_en   = !out_valid_r || out_tready;
  assign b_free    = !b_valid_r || pipe_en;
  assign a_adv     = a_valid_r && (!a_last_r || b_free);
  assign b_load    = a_adv && a_last_r;
  assign in_tready = !a_valid_r || a_adv;

  assign loc_lo_nxt = vmin(loc_lo_r, a_pos_r);
  assign loc_hi_nxt = vmax(loc_hi_r, a_pos_r);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_pos_r.x <= in_tdata[31:0];
      a_pos_r.y <= in_tdata[63:32];
      a_pos_r.z <= in_tdata[95:64];
      a_last_r  <= in_tlast;
    end
    if (b_load) begin
      box_lo_r <= loc_lo_nxt;
      box_hi_r <= loc_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      loc_lo_r  <= '{z: POS_MAX, y: POS_MAX, x: POS_MAX};
      loc_hi_r  <= '{z: POS_MIN, y: POS_MIN, x: POS_MIN};
    end else begin
      a_valid_r <= in_tready ? in_tvalid : a_valid_r;
      if (a_adv) begin
        if (a_last_r) begin
          loc_lo_r <= '{z: POS_MAX, y: POS_MAX, x: POS_MAX};
          loc_hi_r <= '{z: POS_MIN, y: POS_MIN, x: POS_MIN};
        end else begin
          loc_lo_r <= loc_lo_nxt;
          loc_hi_r <= loc_hi_nxt;
        end
      end
    end
  end

  tbb_row u_row_x (
    .clk(clk), .en(pipe_en), .box_lo(box_lo_r), .box_hi(box_hi_r),
    .xy_coeffs(xrow_xy_r), .z_offset(xrow_zt_r), .row_min(row_lo.x), .row_max(row_hi.x)
  );

  tbb_row u_row_y (
    .clk(clk), .en(pipe_en), .box_lo(box_lo_r), .box_hi(box_hi_r),
    .xy_coeffs(yrow_xy_r), .z_offset(yrow_zt_r), .row_min(row_lo.y), .row_max(row_hi.y)
  );

  tbb_row u_row_z (
    .clk(clk), .en(pipe_en), .box_lo(box_lo_r), .box_hi(box_hi_r),
    .xy_coeffs(zrow_xy_r), .z_offset(zrow_zt_r), .row_min(row_lo.z), .row_max(row_hi.z)
  );

  assign world_lo_nxt = vmin(world_lo_r, row_lo);
  assign world_hi_nxt = vmax(world_hi_r, row_hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      world_lo_r  <= '{z: POS_MAX, y: POS_MAX, x: POS_MAX};
      world_hi_r  <= '{z: POS_MIN, y: POS_MIN, x: POS_MIN};
    end else begin
      if (pipe_en) begin
        b_valid_r   <= b_load;
        c_valid_r   <= b_valid_r;
        d_valid_r   <= c_valid_r;
        e_valid_r   <= d_valid_r;
        out_valid_r <= e_valid_r;
        if (e_valid_r) begin
          world_lo_r <= world_lo_nxt;
          world_hi_r <= world_hi_nxt;
        end
      end else if (b_load) begin
        b_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && e_valid_r) begin
      out_data_r <= {world_hi_nxt.z, world_hi_nxt.y, world_hi_nxt.x,
                     world_lo_nxt.z, world_lo_nxt.y, world_lo_nxt.x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/tbb_row.sv =====
`default_nettype none

// One output row of the affine transform, evaluated for the smallest and the
// largest result over the box. Each axis contributes its smaller or larger
// product independently, and the floor shift and saturation keep order.
module tbb_row (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire tbb_pkg::vec_t                 box_lo,
  input  wire tbb_pkg::vec_t                 box_hi,
  input  wire logic [tbb_pkg::RegW-1:0]      xy_coeffs,
  input  wire logic [tbb_pkg::RegW-1:0]      z_offset,
  output logic signed [tbb_pkg::CoordW-1:0]  row_min,
  output logic signed [tbb_pkg::CoordW-1:0]  row_max
);
  import tbb_pkg::*;

  logic signed [CoordW-1:0] cx, cy, cz, tr;
  logic signed [ProdW-1:0]  prod_lo_r [3];
  logic signed [ProdW-1:0]  prod_hi_r [3];
  logic signed [ProdW-1:0]  sel_min_r [3];
  logic signed [ProdW-1:0]  sel_max_r [3];
  logic signed [SumW-1:0]   sum_min_r, sum_max_r;
  logic signed [SumW-1:0]   shift_min, shift_max;
  logic signed [SumW-1:0]   tr_ext;

  assign cx = xy_coeffs[63:32];
  assign cy = xy_coeffs[31:0];
  assign cz = z_offset[63:32];
  assign tr = z_offset[31:0];
  assign tr_ext = SumW'(tr) <<< FracBits;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SumW-1:0] v);
    if (v > SumW'(POS_MAX)) begin
      sat = POS_MAX;
    end else if (v < SumW'(POS_MIN)) begin
      sat = POS_MIN;
    end else begin
      sat = v[CoordW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo_r[0] <= ProdW'(cx) * ProdW'(box_lo.x);
      prod_hi_r[0] <= ProdW'(cx) * ProdW'(box_hi.x);
      prod_lo_r[1] <= ProdW'(cy) * ProdW'(box_lo.y);
      prod_hi_r[1] <= ProdW'(cy) * ProdW'(box_hi.y);
      prod_lo_r[2] <= ProdW'(cz) * ProdW'(box_lo.z);
      prod_hi_r[2] <= ProdW'(cz) * ProdW'(box_hi.z);
      for (int i = 0; i < 3; i++) begin
        sel_min_r[i] <= (prod_hi_r[i] < prod_lo_r[i]) ? prod_hi_r[i] : prod_lo_r[i];
        sel_max_r[i] <= (prod_hi_r[i] > prod_lo_r[i]) ? prod_hi_r[i] : prod_lo_r[i];
      end
      sum_min_r <= SumW'(sel_min_r[0]) + SumW'(sel_min_r[1]) + SumW'(sel_min_r[2]) + tr_ext;
      sum_max_r <= SumW'(sel_max_r[0]) + SumW'(sel_max_r[1]) + SumW'(sel_max_r[2]) + tr_ext;
    end
  end

  assign shift_min = sum_min_r >>> FracBits;
  assign shift_max = sum_max_r >>> FracBits;
  assign row_min   = sat(shift_min);
  assign row_max   = sat(shift_max);

endmodule

`default_nettype wire

// ===== sim/tb_transformed_bounding_box_top.sv =====
`default_nettype none

module tb_transformed_bounding_box_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 12;

  class world_box_model;
    logic [RegW-1:0] matrix [NumRegs];
    logic signed [CoordW-1:0] local_lo [3];
    logic signed [CoordW-1:0] local_hi [3];
    logic signed [CoordW-1:0] world_lo [3];
    logic signed [CoordW-1:0] world_hi [3];
    logic [191:0] boxes_due [$];
    int errors;

    function new();
      matrix[REG_XROW_XY] = XROW_XY_RST;
      matrix[REG_XROW_ZT] = XROW_ZT_RST;
      matrix[REG_YROW_XY] = YROW_XY_RST;
      matrix[REG_YROW_ZT] = YROW_ZT_RST;
      matrix[REG_ZROW_XY] = ZROW_XY_RST;
      matrix[REG_ZROW_ZT] = ZROW_ZT_RST;
      for (int i = 0; i < 3; i++) begin
        local_lo[i] = POS_MAX;
        local_hi[i] = POS_MIN;
        world_lo[i] = POS_MAX;
        world_hi[i] = POS_MIN;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
      if (idx < NumRegs) matrix[idx] = val;
    endfunction

    // The sum is formed exactly, floored by the arithmetic shift, then saturated.
    function logic signed [CoordW-1:0] transform_row(int row, logic signed [CoordW-1:0] x,
                                                     logic signed [CoordW-1:0] y,
                                                     logic signed [CoordW-1:0] z);
      logic signed [CoordW-1:0] cx, cy, cz, t;
      logic signed [79:0] wcx, wcy, wcz, wt, wx, wy, wz, acc, q;
      cx = matrix[2*row][63:32];
      cy = matrix[2*row][31:0];
      cz = matrix[2*row+1][63:32];
      t = matrix[2*row+1][31:0];
      wcx = cx;
      wcy = cy;
      wcz = cz;
      wt = t;
      wx = x;
      wy = y;
      wz = z;
      acc = wcx * wx + wcy * wy + wcz * wz + (wt <<< FracBits);
      q = acc >>> FracBits;
      if (q > POS_MAX) return POS_MAX;
      if (q < POS_MIN) return POS_MIN;
      return q[31:0];
    endfunction

    function void take_vertex(logic [95:0] pos, bit last);
      logic signed [CoordW-1:0] v, x, y, z, w;
      logic [191:0] box_word;
      for (int i = 0; i < 3; i++) begin
        v = pos[32*i +: 32];
        if (v < local_lo[i]) local_lo[i] = v;
        if (v > local_hi[i]) local_hi[i] = v;
      end
      if (!last) return;
      for (int c = 0; c < 8; c++) begin
        x = ((c & 1) != 0) ? local_hi[0] : local_lo[0];
        y = ((c & 2) != 0) ? local_hi[1] : local_lo[1];
        z = ((c & 4) != 0) ? local_hi[2] : local_lo[2];
        for (int r = 0; r < 3; r++) begin
          w = transform_row(r, x, y, z);
          if (w < world_lo[r]) world_lo[r] = w;
          if (w > world_hi[r]) world_hi[r] = w;
        end
      end
      box_word = {world_hi[2], world_hi[1], world_hi[0],
                  world_lo[2], world_lo[1], world_lo[0]};
      boxes_due.insert(boxes_due.size(), box_word);
      for (int i = 0; i < 3; i++) begin
        local_lo[i] = POS_MAX;
        local_hi[i] = POS_MIN;
      end
    endfunction

    function void check_box(logic [191:0] got);
      string names [6] = '{"world_min_x", "world_min_y", "world_min_z",
                           "world_max_x", "world_max_y", "world_max_z"};
      logic [191:0] exp_box;
      if (boxes_due.size() == 0) begin
        $error("unexpected world box word %h", got);
        errors++;
        return;
      end
      exp_box = boxes_due.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[32*i +: 32] !== exp_box[32*i +: 32]) begin
          $error("%s: expected %0d, actual %0d", names[i],
                 $signed(exp_box[32*i +: 32]), $signed(got[32*i +: 32]));
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;

  world_box_model boxes;
  bit steady = 1'b0;
  int unsigned cycles = 0;

  transformed_bounding_box_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_transformed_bounding_box_top: errors");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) boxes.check_box(out_tdata);
  end

  // Two's complement value drawn from [-2^b, 2^b - 1]; full range from 31 bits up.
  function automatic logic [31:0] rand_signed(int b);
    logic [31:0] mask, v;
    if (b >= 31) return $urandom;
    if (b < 0) b = 0;
    mask = (32'h1 << (b + 1)) - 1;
    v = $urandom & mask;
    if (v[b]) v = v | ~mask;
    return v;
  endfunction

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    boxes.take_vertex({z, y, x}, last);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    boxes.write_reg(idx, val);
  endtask

  task automatic load_matrix(logic [RegW-1:0] xxy, logic [RegW-1:0] xzt,
                             logic [RegW-1:0] yxy, logic [RegW-1:0] yzt,
                             logic [RegW-1:0] zxy, logic [RegW-1:0] zzt);
    write_reg(REG_XROW_XY, xxy);
    write_reg(REG_XROW_ZT, xzt);
    write_reg(REG_YROW_XY, yxy);
    write_reg(REG_YROW_ZT, yzt);
    write_reg(REG_ZROW_XY, zxy);
    write_reg(REG_ZROW_ZT, zzt);
    if ($urandom_range(1)) write_reg(CfgIdxW'(NumRegs + $urandom_range(1)), {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (boxes.boxes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Output magnitude grows with lvl so the world box widens gradually.
  task automatic random_phase(int lvl, int count);
    int kb, cb, n, len;
    bit last;
    kb = $urandom_range(0, (lvl + 15 > 30) ? 30 : lvl + 15);
    cb = lvl + 16 - kb;
    if (cb > 31) cb = 31;
    load_matrix({rand_signed(kb), rand_signed(kb)}, {rand_signed(kb), rand_signed(lvl)},
                {rand_signed(kb), rand_signed(kb)}, {rand_signed(kb), rand_signed(lvl)},
                {rand_signed(kb), rand_signed(kb)}, {rand_signed(kb), rand_signed(lvl)});
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 12);
      for (int j = 0; j < len; j++) begin
        last = (j == len - 1) && ($urandom_range(9) != 0);
        send_vertex(rand_signed(cb), rand_signed(cb), rand_signed(cb), last);
        n++;
      end
    end
    send_vertex(rand_signed(cb), rand_signed(cb), rand_signed(cb), 1'b1);
    settle();
  endtask

  initial begin
    boxes = new;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_vertex(32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 1'b1);
    send_vertex(32'hFFFB_0000, 32'h0007_0000, 32'hFFF7_0000, 1'b0);
    send_vertex(32'h0064_0000, 32'hFF9C_0000, 32'h0032_0000, 1'b0);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    settle();
    write_reg(CfgIdxW'(NumRegs), 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgIdxW'(NumRegs + 1), 64'h1234_5678_9ABC_DEF0);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_vertex(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b1);
    settle();

    load_matrix(64'h0000_0001_FFFF_FFFF, 64'h0000_0001_FFFF_FFFD,
                64'hFFFF_FFFF_0000_0002, 64'h0000_0000_0000_0007,
                64'h0000_0000_0000_0000, 64'h0000_0001_FFFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    settle();

    load_matrix(64'h7FFF_FFFF_8000_0000, 64'hFFFF_FFFF_0000_0000,
                64'h8000_0000_7FFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                64'h0000_0000_FFFF_FFFF, 64'h7FFF_FFFF_0000_8000);
    send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0);
    send_vertex(32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0001, 1'b1);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    settle();

    for (int p = 0; p < 10; p++) begin
      steady = (p == 4 || p == 5);
      random_phase(4 + 3 * p, 45);
    end
    steady = 1'b0;

    load_matrix(64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
                64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    for (int j = 0; j < 12; j++) send_vertex($urandom, $urandom, $urandom, $urandom_range(1));
    send_vertex($urandom, $urandom, $urandom, 1'b1);
    settle();
    random_phase(31, 20);

    if (boxes.errors == 0) begin
      $display("tb_transformed_bounding_box_top: clean");
    end else begin
      $display("tb_transformed_bounding_box_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== transformed_bounding_box_top.f =====
rtl/tbb_pkg.sv
rtl/tbb_row.sv
rtl/transformed_bounding_box_top.sv
sim/tb_transformed_bounding_box_top.sv
